>>> rtl/cbts_pkg.sv
// ----------------------------------------------------------------------------
// cbts_pkg - CAN bit timing solver package
// Widths, limits and shared types for the bit timing solver and its divider.
// ----------------------------------------------------------------------------
package cbts_pkg;

  localparam int unsigned CLK_W   = 30;
  localparam int unsigned RATE_W  = 22;
  localparam int unsigned DIV_W   = 30;
  localparam int unsigned PERM_W  = 15;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned SUM_W   = 5;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned PRE_OUT_W  = 11;
  localparam int unsigned SJW_OUT_W  = 4;
  localparam int unsigned SEG1_OUT_W = 5;
  localparam int unsigned SEG2_OUT_W = 4;
  localparam int unsigned PERM_OUT_W = 10;

  localparam int unsigned CLOCK_RESET   = 80000000;
  localparam int unsigned FAST_RATE     = 1000000;
  localparam int unsigned FAST_QUANTA   = 10;
  localparam int unsigned SLOW_QUANTA   = 17;
  localparam int unsigned SAMPLE_LIMIT  = 900;
  localparam int unsigned PERMILLE      = 1000;
  localparam int unsigned JUMP_WIDTH    = 8;
  localparam int unsigned MIN_SUM       = 2;
  localparam int unsigned MAX_PRESCALER = 1024;
  localparam int unsigned MAX_SEG_ONE   = 16;
  localparam int unsigned MAX_SEG_TWO   = 8;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/cbts_serdiv.sv
// ----------------------------------------------------------------------------
// cbts_serdiv - bit-serial restoring divider
// One quotient bit per cycle; full 30-bit operation or a short 15-bit one.
// ----------------------------------------------------------------------------
module cbts_serdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          short_op,
  input  logic [cbts_pkg::DIV_W-1:0]    dividend,
  input  logic [cbts_pkg::DIV_W-1:0]    divisor,
  output cbts_pkg::div_stat_t           stat,
  output logic [cbts_pkg::DIV_W-1:0]    quotient,
  output logic [cbts_pkg::DIV_W-1:0]    remainder
);

  localparam int unsigned W  = cbts_pkg::DIV_W;
  localparam int unsigned SW = cbts_pkg::PERM_W;

  logic [W-1:0]                 dq_r;
  logic [W-1:0]                 rem_r;
  logic [W-1:0]                 dvs_r;
  logic [cbts_pkg::CNT_W-1:0]   cnt_r;
  logic                         busy_r;
  logic                         done_r;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       fits;

  assign trial = {rem_r, dq_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == cbts_pkg::CNT_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dq_r  <= short_op ? {dividend[SW-1:0], {(W-SW){1'b0}}} : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= short_op ? cbts_pkg::CNT_W'(SW) : cbts_pkg::CNT_W'(W);
    end else if (busy_r) begin
      dq_r  <= {dq_r[W-2:0], fits};
      rem_r <= fits ? diff[W-1:0] : trial[W-1:0];
      cnt_r <= cnt_r - cbts_pkg::CNT_W'(1);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;
  assign remainder = rem_r;

endmodule

>>> rtl/can_bit_timing_solver_core.sv
// ----------------------------------------------------------------------------
// can_bit_timing_solver_core - CAN bit timing solver
// Finds prescaler, segments and sample point for a requested bitrate.
// ----------------------------------------------------------------------------
// A zero bitrate fails at once: out_strobe is registered in the cycle after
// start. Otherwise the single bit-serial divider runs clock/bitrate, modulo
// tries (up to 15), one or two sample point passes and the bitrate check.
// A start is taken only when idle; busy is high until out_strobe.
// The result strobe is high for one cycle only; the receiver cannot stall it.
// Reset is synchronous: control clears and clock_hz returns to 80 MHz.
module can_bit_timing_solver_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [cbts_pkg::RATE_W-1:0]          in_target_bitrate,
  output logic                                 out_strobe,
  output logic                                 out_valid_res,
  output logic [cbts_pkg::PRE_OUT_W-1:0]       out_prescaler_out,
  output logic [cbts_pkg::SJW_OUT_W-1:0]       out_jump_width,
  output logic [cbts_pkg::SEG1_OUT_W-1:0]      out_seg_one,
  output logic [cbts_pkg::SEG2_OUT_W-1:0]      out_seg_two,
  output logic [cbts_pkg::PERM_OUT_W-1:0]      out_sample_permille,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cbts_pkg::ADDR_W-1:0]          paddr,
  input  logic [cbts_pkg::DATA_W-1:0]          pwdata,
  output logic [cbts_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  localparam int unsigned W  = cbts_pkg::DIV_W;
  localparam int unsigned SW = cbts_pkg::SUM_W;
  localparam int unsigned PW = cbts_pkg::PERM_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_QUOT  = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_PERM1 = 6'b001000,
    ST_PERM2 = 6'b010000,
    ST_EXACT = 6'b100000
  } state_t;

  // segment one as seven eighths of the sum, rounded to nearest, and strictly below it
  function automatic logic [SW-1:0] one_near(input logic [SW-1:0] s);
    logic [7:0] s7;
    s7 = {s, 3'b000} - 8'(s);
    return SW'((s7 + 8'd3) >> 3);
  endfunction

  function automatic logic [SW-1:0] one_tz(input logic [SW-1:0] s);
    logic [7:0] s7;
    s7 = {s, 3'b000} - 8'(s);
    return SW'((s7 - 8'd1) >> 3);
  endfunction

  function automatic logic [W-1:0] perm_num(input logic [SW-1:0] one);
    logic [PW-1:0] p;
    p = PW'(one + SW'(1)) * PW'(cbts_pkg::PERMILLE);
    return W'(p);
  endfunction

  state_t                         state_r, state_nxt;
  logic [cbts_pkg::CLK_W-1:0]     clock_hz_r;
  logic [cbts_pkg::RATE_W-1:0]    rate_r, rate_nxt;
  logic [W-1:0]                   quot_r, quot_nxt;
  logic [SW-1:0]                  sum_r, sum_nxt;
  logic [SW-1:0]                  one_r, one_nxt;
  logic [cbts_pkg::PRE_OUT_W-1:0] presc_r, presc_nxt;
  logic [cbts_pkg::PERM_OUT_W-1:0] perm_r, perm_nxt;

  logic                           strobe_r;
  logic                           res_ok_r;
  logic [cbts_pkg::PRE_OUT_W-1:0] res_pre_r;
  logic [cbts_pkg::SJW_OUT_W-1:0] res_sjw_r;
  logic [cbts_pkg::SEG1_OUT_W-1:0] res_seg1_r;
  logic [cbts_pkg::SEG2_OUT_W-1:0] res_seg2_r;
  logic [cbts_pkg::PERM_OUT_W-1:0] res_perm_r;

  logic                           div_load;
  logic                           div_short;
  logic [W-1:0]                   div_dvd;
  logic [W-1:0]                   div_dvs;
  cbts_pkg::div_stat_t            div_stat;
  logic [W-1:0]                   div_q;
  logic [W-1:0]                   div_rem;

  logic                           fin;
  logic                           fin_ok;
  logic [SW-1:0]                  two;
  logic                           cfg_wr;

  cbts_serdiv u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (div_load),
    .short_op  (div_short),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? '0 : cbts_pkg::DATA_W'(clock_hz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= cbts_pkg::CLK_W'(cbts_pkg::CLOCK_RESET);
    end else if (cfg_wr) begin
      clock_hz_r <= pwdata[cbts_pkg::CLK_W-1:0];
    end
  end

  assign two = sum_r - one_r;

  always_comb begin
    state_nxt = state_r;
    rate_nxt  = rate_r;
    quot_nxt  = quot_r;
    sum_nxt   = sum_r;
    one_nxt   = one_r;
    presc_nxt = presc_r;
    perm_nxt  = perm_r;
    div_load  = 1'b0;
    div_short = 1'b0;
    div_dvd   = quot_r;
    div_dvs   = W'(sum_r) + W'(1);
    fin       = 1'b0;
    fin_ok    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          rate_nxt = in_target_bitrate;
          sum_nxt  = (in_target_bitrate >= cbts_pkg::RATE_W'(cbts_pkg::FAST_RATE)) ?
                     SW'(cbts_pkg::FAST_QUANTA - 1) : SW'(cbts_pkg::SLOW_QUANTA - 1);
          if (in_target_bitrate == '0) begin
            fin = 1'b1;
          end else begin
            div_load  = 1'b1;
            div_dvd   = W'(clock_hz_r);
            div_dvs   = W'(in_target_bitrate);
            state_nxt = ST_QUOT;
          end
        end
      end
      ST_QUOT: begin
        if (div_stat.done) begin
          quot_nxt  = div_q;
          div_load  = 1'b1;
          div_dvd   = div_q;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_stat.done) begin
          if (div_rem != '0) begin
            if (sum_r <= SW'(cbts_pkg::MIN_SUM)) begin
              fin       = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              sum_nxt  = sum_r - SW'(1);
              div_load = 1'b1;
              div_dvs  = W'(sum_r);
            end
          end else if (div_q == '0 || div_q > W'(cbts_pkg::MAX_PRESCALER)) begin
            fin       = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            presc_nxt = div_q[cbts_pkg::PRE_OUT_W-1:0];
            one_nxt   = one_near(sum_r);
            div_load  = 1'b1;
            div_short = 1'b1;
            div_dvd   = perm_num(one_near(sum_r));
            state_nxt = ST_PERM1;
          end
        end
      end
      ST_PERM1: begin
        if (div_stat.done) begin
          div_load = 1'b1;
          if (div_q > W'(cbts_pkg::SAMPLE_LIMIT)) begin
            one_nxt   = one_tz(sum_r);
            div_short = 1'b1;
            div_dvd   = perm_num(one_tz(sum_r));
            state_nxt = ST_PERM2;
          end else begin
            perm_nxt  = div_q[cbts_pkg::PERM_OUT_W-1:0];
            div_dvd   = W'(clock_hz_r);
            div_dvs   = quot_r;
            state_nxt = ST_EXACT;
          end
        end
      end
      ST_PERM2: begin
        if (div_stat.done) begin
          perm_nxt  = div_q[cbts_pkg::PERM_OUT_W-1:0];
          div_load  = 1'b1;
          div_dvd   = W'(clock_hz_r);
          div_dvs   = quot_r;
          state_nxt = ST_EXACT;
        end
      end
      ST_EXACT: begin
        if (div_stat.done) begin
          fin       = 1'b1;
          fin_ok    = (div_q == W'(rate_r)) &&
                      (one_r != '0) && (one_r <= SW'(cbts_pkg::MAX_SEG_ONE)) &&
                      (two != '0) && (two <= SW'(cbts_pkg::MAX_SEG_TWO));
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    rate_r  <= rate_nxt;
    quot_r  <= quot_nxt;
    sum_r   <= sum_nxt;
    one_r   <= one_nxt;
    presc_r <= presc_nxt;
    perm_r  <= perm_nxt;
    if (fin) begin
      res_ok_r   <= fin_ok;
      res_pre_r  <= fin_ok ? presc_r : '0;
      res_sjw_r  <= fin_ok ? cbts_pkg::SJW_OUT_W'(cbts_pkg::JUMP_WIDTH) : '0;
      res_seg1_r <= fin_ok ? one_r : '0;
      res_seg2_r <= fin_ok ? two[cbts_pkg::SEG2_OUT_W-1:0] : '0;
      res_perm_r <= fin_ok ? perm_r : '0;
    end
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_strobe          = strobe_r;
  assign out_valid_res       = res_ok_r;
  assign out_prescaler_out   = res_pre_r;
  assign out_jump_width      = res_sjw_r;
  assign out_seg_one         = res_seg1_r;
  assign out_seg_two         = res_seg2_r;
  assign out_sample_permille = res_perm_r;

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) || $past(start)))
    else $error("result strobe without an item in flight");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |->
      (out_prescaler_out == '0 && out_jump_width == '0 && out_seg_one == '0 &&
       out_seg_two == '0 && out_sample_permille == '0))
    else $error("failed item carries non-zero fields");

  a_ok_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_valid_res) |->
      (out_prescaler_out != '0 &&
       out_prescaler_out <= cbts_pkg::PRE_OUT_W'(cbts_pkg::MAX_PRESCALER) &&
       out_jump_width == cbts_pkg::SJW_OUT_W'(cbts_pkg::JUMP_WIDTH) &&
       out_seg_one != '0 && out_seg_two != '0 &&
       out_sample_permille <= cbts_pkg::PERM_OUT_W'(cbts_pkg::SAMPLE_LIMIT)))
    else $error("valid item outside timing limits");

  a_div_idle_load: assert property (@(posedge clk) disable iff (!rst_n)
    div_load |-> !div_stat.busy)
    else $error("divider loaded while busy");

endmodule
